>>> rtl/core/sawtc_pkg.sv
// Shared constants, codes and types of the set-associative write-through cache.
`default_nettype none
package sawtc_pkg;

    localparam int ADDR_BITS        = 32;
    localparam int LINE_OFFSET_BITS = 4;
    localparam int WAY_BITS         = 2;
    localparam int CAPACITY_BITS    = 12;

    localparam int SET_BITS   = CAPACITY_BITS - WAY_BITS - LINE_OFFSET_BITS;
    localparam int NUM_SETS   = 1 << SET_BITS;
    localparam int NUM_WAYS   = 1 << WAY_BITS;
    localparam int NUM_LINES  = 1 << (CAPACITY_BITS - LINE_OFFSET_BITS);
    localparam int LINE_BYTES = 1 << LINE_OFFSET_BITS;
    localparam int LINE_W     = LINE_BYTES * 8;
    localparam int BEAT_BYTES = 8;
    localparam int BEATS      = LINE_BYTES / BEAT_BYTES;
    localparam int BEAT_BITS  = LINE_OFFSET_BITS - 3;
    localparam int TAG_BITS   = ADDR_BITS - LINE_OFFSET_BITS - SET_BITS;
    localparam int DATA_W     = 64;
    localparam int BYTES_W    = 4;

    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_REFILL = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_FETCH = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    typedef struct packed {
        logic [1:0] act;
        logic       bad;
        logic       hit;
    } t_status;

    typedef struct packed {
        logic                 emit_fault;
        logic                 emit_write;
        logic                 emit_read_hit;
        logic                 emit_fetch;
        logic                 emit_refill;
        logic                 write_hit;
        logic                 start_miss;
        logic                 refill_beat;
        logic                 refill_last;
        logic [BEAT_BITS-1:0] beat;
    } t_cmd;

endpackage
`default_nettype wire

>>> rtl/core/set_assoc_write_through_cache_unit.sv
// Top level: set-associative write-through cache, random replacement.
// Each accepted word is handled in order: the registered tag/line RAM read, then the decision in the lookup state.
// A result word, if any, appears in the cycle after the busy cycle, for one cycle.
// A new word is taken only while busy is low, not while the last one is still in its lookup.
// Synchronous active-low reset clears all valid bits and the miss state, and sets the LFSR to 1.
// The receiver cannot stall: results are strobed and never held.
`default_nettype none
module set_assoc_write_through_cache_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_access_addr,
    input  wire logic [3:0]  i_access_bytes,
    input  wire logic [63:0] i_write_value,
    input  wire logic [63:0] i_refill_word,
    output logic             o_result_valid,
    output logic [1:0]       o_result_kind,
    output logic [31:0]      o_mem_addr,
    output logic [63:0]      o_result_data,
    output logic [3:0]       o_result_bytes,
    output logic             o_was_hit,
    output logic             o_fault
);

    sawtc_pkg::t_cmd    cmd;
    sawtc_pkg::t_status status;
    logic               accept;

    assign accept = start && !busy;

    sawtc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    sawtc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_action       (i_action),
        .i_access_addr  (i_access_addr),
        .i_access_bytes (i_access_bytes),
        .i_write_value  (i_write_value),
        .i_refill_word  (i_refill_word),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_result_valid (o_result_valid),
        .o_result_kind  (o_result_kind),
        .o_mem_addr     (o_mem_addr),
        .o_result_data  (o_result_data),
        .o_result_bytes (o_result_bytes),
        .o_was_hit      (o_was_hit),
        .o_fault        (o_fault)
    );

    a_result_after_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result word without a preceding lookup cycle");

    a_single_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("lookup lasted more than one cycle");

    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.emit_fault, cmd.emit_write, cmd.emit_read_hit,
                  cmd.emit_fetch, cmd.emit_refill}))
        else $error("more than one result word requested");

    a_fault_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_fault) |-> (!o_was_hit && (o_result_data == 64'd0)))
        else $error("faulted word carries data or hit");

endmodule
`default_nettype wire

>>> rtl/core/sawtc_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module sawtc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/core/sawtc_ctrl.sv
// Controller: access sequencing, miss tracking and refill beat counting.
`default_nettype none
module sawtc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire sawtc_pkg::t_status i_status,
    output sawtc_pkg::t_cmd        o_cmd,
    output logic                   o_busy
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    logic                            r_state, n_state;
    logic                            r_pend, n_pend;
    logic [sawtc_pkg::BEAT_BITS-1:0] r_beat, n_beat;
    logic                            last_beat;

    assign o_busy    = (r_state == S_LOOK);
    assign last_beat = (r_beat == sawtc_pkg::BEAT_BITS'(sawtc_pkg::BEATS - 1));

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        n_beat  = r_beat;
        o_cmd   = '0;
        o_cmd.beat = r_beat;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_IDLE;
                if (i_status.act == sawtc_pkg::ACT_REFILL) begin
                    if (r_pend) begin
                        o_cmd.refill_beat = 1'b1;
                        if (last_beat) begin
                            o_cmd.refill_last = 1'b1;
                            o_cmd.emit_refill = 1'b1;
                            n_pend = 1'b0;
                            n_beat = '0;
                        end else begin
                            n_beat = r_beat + 1'b1;
                        end
                    end
                end else if (i_status.act == sawtc_pkg::ACT_NONE || r_pend) begin
                    // dropped: no word
                end else if (i_status.bad) begin
                    o_cmd.emit_fault = 1'b1;
                end else if (i_status.act == sawtc_pkg::ACT_WRITE) begin
                    o_cmd.emit_write = 1'b1;
                    o_cmd.write_hit  = i_status.hit;
                end else if (i_status.hit) begin
                    o_cmd.emit_read_hit = 1'b1;
                end else begin
                    o_cmd.emit_fetch = 1'b1;
                    o_cmd.start_miss = 1'b1;
                    n_pend = 1'b1;
                    n_beat = '0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_beat  <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_beat  <= n_beat;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/sawtc_dp.sv
// Datapath: tag and line stores, valid bits, replacement LFSR and result register.
`default_nettype none
module sawtc_dp (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic [1:0]                i_action,
    input  wire logic [31:0]               i_access_addr,
    input  wire logic [3:0]                i_access_bytes,
    input  wire logic [63:0]               i_write_value,
    input  wire logic [63:0]               i_refill_word,
    input  wire sawtc_pkg::t_cmd           i_cmd,
    output sawtc_pkg::t_status             o_status,
    output logic                           o_result_valid,
    output logic [1:0]                     o_result_kind,
    output logic [31:0]                    o_mem_addr,
    output logic [63:0]                    o_result_data,
    output logic [3:0]                     o_result_bytes,
    output logic                           o_was_hit,
    output logic                           o_fault
);

    localparam int OFF  = sawtc_pkg::LINE_OFFSET_BITS;
    localparam int SB   = sawtc_pkg::SET_BITS;
    localparam int WB   = sawtc_pkg::WAY_BITS;
    localparam int NW   = sawtc_pkg::NUM_WAYS;
    localparam int LW   = sawtc_pkg::LINE_W;
    localparam int TB   = sawtc_pkg::TAG_BITS;

    function automatic logic [63:0] f_low_bytes(input logic [63:0] v, input logic [3:0] n);
        logic [63:0] res;
        for (int b = 0; b < 8; b++) begin
            res[b*8 +: 8] = (4'(b) < n) ? v[b*8 +: 8] : 8'h00;
        end
        return res;
    endfunction

    // captured access
    logic [1:0]  r_act;
    logic [31:0] r_addr;
    logic [3:0]  r_bytes;
    logic [63:0] r_wval;
    logic [63:0] r_refill;

    // miss bookkeeping
    logic [31:0]  r_pend_addr;
    logic [3:0]   r_pend_bytes;
    logic [WB-1:0] r_victim;
    logic [15:0]  r_lfsr;
    logic [15:0]  n_lfsr;
    logic [63:0]  r_fill [sawtc_pkg::BEATS];
    logic [sawtc_pkg::NUM_LINES-1:0] r_valid;

    logic [OFF-1:0] off;
    logic [SB-1:0]  set, pend_set, ram_set;
    logic [TB-1:0]  tag;
    logic [TB-1:0]  tag_rd  [NW];
    logic [LW-1:0]  line_rd [NW];
    logic [NW-1:0]  way_match;
    logic           hit;
    logic [WB-1:0]  hit_way;
    logic [LW-1:0]  hit_line, merged, fill_line, wr_line;
    logic [5:0]     end_sum;

    assign off      = r_addr[OFF-1:0];
    assign set      = r_addr[OFF +: SB];
    assign tag      = r_addr[OFF+SB +: TB];
    assign pend_set = r_pend_addr[OFF +: SB];
    assign end_sum  = 6'(off) + 6'(r_bytes);

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_act    <= i_action;
            r_addr   <= i_access_addr;
            r_bytes  <= i_access_bytes;
            r_wval   <= i_write_value;
            r_refill <= i_refill_word;
        end
    end

    // RAM port: write address while updating, else the incoming access's set
    always_comb begin
        if (i_cmd.write_hit) begin
            ram_set = set;
        end else if (i_cmd.refill_last) begin
            ram_set = pend_set;
        end else begin
            ram_set = i_access_addr[OFF +: SB];
        end
    end

    for (genvar w = 0; w < NW; w++) begin : g_way
        logic tag_we, line_we;
        assign tag_we  = i_cmd.refill_last && (r_victim == WB'(w));
        assign line_we = tag_we || (i_cmd.write_hit && (hit_way == WB'(w)));

        sawtc_ram #(.WIDTH(TB), .DEPTH(sawtc_pkg::NUM_SETS)) u_tag (
            .i_clk   (i_clk),
            .i_we    (tag_we),
            .i_addr  (ram_set),
            .i_wdata (r_pend_addr[OFF+SB +: TB]),
            .o_rdata (tag_rd[w])
        );

        sawtc_ram #(.WIDTH(LW), .DEPTH(sawtc_pkg::NUM_SETS)) u_line (
            .i_clk   (i_clk),
            .i_we    (line_we),
            .i_addr  (ram_set),
            .i_wdata (wr_line),
            .o_rdata (line_rd[w])
        );

        assign way_match[w] = r_valid[{WB'(w), set}] && (tag_rd[w] == tag);
    end

    always_comb begin
        hit_way = '0;
        for (int w = NW - 1; w >= 0; w--) begin
            if (way_match[w]) begin
                hit_way = WB'(w);
            end
        end
    end

    assign hit      = |way_match;
    assign hit_line = line_rd[hit_way];

    // byte merge of write data into the hit line
    always_comb begin
        logic [OFF:0] k;
        for (int b = 0; b < sawtc_pkg::LINE_BYTES; b++) begin
            k = (OFF+1)'(b) - {1'b0, off};
            if ((OFF'(b) >= off) && (k < (OFF+1)'(r_bytes))) begin
                merged[b*8 +: 8] = r_wval[k[2:0]*8 +: 8];
            end else begin
                merged[b*8 +: 8] = hit_line[b*8 +: 8];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < sawtc_pkg::BEATS; i++) begin
            fill_line[i*64 +: 64] = (i == sawtc_pkg::BEATS - 1) ? r_refill : r_fill[i];
        end
    end

    assign wr_line = i_cmd.write_hit ? merged : fill_line;

    assign o_status.act = r_act;
    assign o_status.bad = (r_bytes == 4'd0) || (r_bytes > 4'd8) ||
                          (end_sum > 6'(sawtc_pkg::LINE_BYTES));
    assign o_status.hit = hit;

    assign n_lfsr = {r_lfsr[14:0], r_lfsr[15] ^ r_lfsr[13] ^ r_lfsr[12] ^ r_lfsr[10]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_lfsr   <= 16'h0001;
            r_victim <= '0;
        end else begin
            if (i_cmd.start_miss) begin
                r_lfsr   <= n_lfsr;
                r_victim <= n_lfsr[WB-1:0];
                r_valid[{n_lfsr[WB-1:0], set}] <= 1'b0;
            end
            if (i_cmd.refill_last) begin
                r_valid[{r_victim, pend_set}] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_miss) begin
            r_pend_addr  <= r_addr;
            r_pend_bytes <= r_bytes;
        end
        if (i_cmd.refill_beat && !i_cmd.refill_last) begin
            r_fill[i_cmd.beat] <= r_refill;
        end
    end

    // result word
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [31:0] r_maddr;
    logic [63:0] r_data;
    logic [3:0]  r_obytes;
    logic        r_hit;
    logic        r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit_fault | i_cmd.emit_write | i_cmd.emit_read_hit |
                           i_cmd.emit_fetch | i_cmd.emit_refill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_fault) begin
            r_kind   <= (r_act == sawtc_pkg::ACT_READ) ? sawtc_pkg::KIND_READ
                                                       : sawtc_pkg::KIND_WRITE;
            r_maddr  <= r_addr;
            r_data   <= '0;
            r_obytes <= r_bytes;
            r_hit    <= 1'b0;
            r_fault  <= 1'b1;
        end else if (i_cmd.emit_write) begin
            r_kind   <= sawtc_pkg::KIND_WRITE;
            r_maddr  <= r_addr;
            r_data   <= f_low_bytes(r_wval, r_bytes);
            r_obytes <= r_bytes;
            r_hit    <= hit;
            r_fault  <= 1'b0;
        end else if (i_cmd.emit_read_hit) begin
            r_kind   <= sawtc_pkg::KIND_READ;
            r_maddr  <= r_addr;
            r_data   <= f_low_bytes(64'(hit_line >> {off, 3'b000}), r_bytes);
            r_obytes <= r_bytes;
            r_hit    <= 1'b1;
            r_fault  <= 1'b0;
        end else if (i_cmd.emit_fetch) begin
            r_kind   <= sawtc_pkg::KIND_FETCH;
            r_maddr  <= {r_addr[31:OFF], {OFF{1'b0}}};
            r_data   <= '0;
            r_obytes <= 4'(sawtc_pkg::BEAT_BYTES);
            r_hit    <= 1'b0;
            r_fault  <= 1'b0;
        end else if (i_cmd.emit_refill) begin
            r_kind   <= sawtc_pkg::KIND_READ;
            r_maddr  <= r_pend_addr;
            r_data   <= f_low_bytes(64'(fill_line >> {r_pend_addr[OFF-1:0], 3'b000}),
                                    r_pend_bytes);
            r_obytes <= r_pend_bytes;
            r_hit    <= 1'b0;
            r_fault  <= 1'b0;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_mem_addr     = r_maddr;
    assign o_result_data  = r_data;
    assign o_result_bytes = r_obytes;
    assign o_was_hit      = r_hit;
    assign o_fault        = r_fault;

endmodule
`default_nettype wire

>>> bench/tb.sv
// Testbench for the set-associative write-through cache: directed table, then random traffic.
`timescale 1ns / 100ps
module tb;
    import sawtc_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [63:0] data;
        logic [3:0]  bytes;
        logic        hit;
        logic        fault;
    } cache_result_t;

    typedef struct {
        logic [1:0]    act;
        logic [31:0]   addr;
        logic [3:0]    bytes;
        logic [63:0]   wval;
        logic [63:0]   rword;
        bit            known;
        cache_result_t res;
    } access_row_t;

    logic        i_clk, i_rst_n, start;
    logic        busy;
    logic [1:0]  i_action;
    logic [31:0] i_access_addr;
    logic [3:0]  i_access_bytes;
    logic [63:0] i_write_value, i_refill_word;
    logic        o_result_valid;
    logic [1:0]  o_result_kind;
    logic [31:0] o_mem_addr;
    logic [63:0] o_result_data;
    logic [3:0]  o_result_bytes;
    logic        o_was_hit, o_fault;

    set_assoc_write_through_cache_unit i_dut (.*);

    // shadow copy of the cache
    logic [TAG_BITS-1:0] tag_mirror [NUM_LINES];
    bit                  valid_mirror [NUM_LINES];
    logic [7:0]          byte_mirror [NUM_LINES][LINE_BYTES];
    bit                  miss_open;
    logic [31:0]         miss_addr;
    logic [3:0]          miss_bytes;
    logic [WAY_BITS-1:0] victim;
    int                  beat_idx;
    logic [15:0]         lfsr;

    cache_result_t due_results[$];
    int            mismatches;
    int            effective;
    logic [31:0]   addr_pool[16];

    initial i_clk = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #(12 * 400000);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic int line_of(int way, logic [31:0] a);
        return way * NUM_SETS + int'(a[LINE_OFFSET_BITS +: SET_BITS]);
    endfunction

    function automatic logic [63:0] line_bytes(int ln, int off, int n);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < n; k++) v[8*k +: 8] = byte_mirror[ln][off + k];
        return v;
    endfunction

    // returns 1 if the word produces a result, r holds it
    function automatic bit cache_predict(access_row_t w, output cache_result_t r);
        int off, ln;
        bit bad;
        off = int'(w.addr[LINE_OFFSET_BITS-1:0]);
        r = '{default: '0};
        if (w.act == ACT_REFILL) begin
            if (!miss_open) return 0;
            ln = line_of(victim, miss_addr);
            for (int k = 0; k < 8; k++) byte_mirror[ln][beat_idx*8 + k] = w.rword[8*k +: 8];
            beat_idx++;
            if (beat_idx < BEATS) return 0;
            tag_mirror[ln] = miss_addr[31 -: TAG_BITS];
            valid_mirror[ln] = 1;
            miss_open = 0;
            beat_idx = 0;
            r = '{KIND_READ, miss_addr,
                  line_bytes(ln, int'(miss_addr[LINE_OFFSET_BITS-1:0]), miss_bytes),
                  miss_bytes, 1'b0, 1'b0};
            return 1;
        end
        if (w.act == ACT_NONE || miss_open) return 0;
        bad = w.bytes == 0 || w.bytes > 8 || off + w.bytes > LINE_BYTES;
        if (bad) begin
            r = '{(w.act == ACT_READ) ? KIND_READ : KIND_WRITE, w.addr, 64'd0, w.bytes, 1'b0, 1'b1};
            return 1;
        end
        ln = -1;
        for (int k = 0; k < NUM_WAYS; k++)
            if (valid_mirror[line_of(k, w.addr)] &&
                tag_mirror[line_of(k, w.addr)] == w.addr[31 -: TAG_BITS]) ln = line_of(k, w.addr);
        if (w.act == ACT_WRITE) begin
            if (ln >= 0)
                for (int k = 0; k < w.bytes; k++) byte_mirror[ln][off + k] = w.wval[8*k +: 8];
            r = '{KIND_WRITE, w.addr, 64'd0, w.bytes, ln >= 0, 1'b0};
            for (int k = 0; k < w.bytes; k++) r.data[8*k +: 8] = w.wval[8*k +: 8];
            return 1;
        end
        if (ln >= 0) begin
            r = '{KIND_READ, w.addr, line_bytes(ln, off, w.bytes), w.bytes, 1'b1, 1'b0};
            return 1;
        end
        lfsr = {lfsr[14:0], lfsr[15] ^ lfsr[13] ^ lfsr[12] ^ lfsr[10]};
        victim = lfsr[WAY_BITS-1:0];
        valid_mirror[line_of(victim, w.addr)] = 0;
        miss_open = 1;
        miss_addr = w.addr;
        miss_bytes = w.bytes;
        beat_idx = 0;
        r = '{KIND_FETCH, {w.addr[31:LINE_OFFSET_BITS], {LINE_OFFSET_BITS{1'b0}}}, 64'd0,
              4'd8, 1'b0, 1'b0};
        return 1;
    endfunction

    // drive one word, wait for it to be taken, then predict
    task automatic send_word(access_row_t w);
        cache_result_t r;
        bit active;
        active = (w.act == ACT_REFILL) ? miss_open : (w.act != ACT_NONE && !miss_open);
        i_action       <= w.act;
        i_access_addr  <= w.addr;
        i_access_bytes <= w.bytes;
        i_write_value  <= w.wval;
        i_refill_word  <= w.rword;
        start          <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (cache_predict(w, r)) due_results.push_back(w.known ? w.res : r);
        if (active) effective++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (due_results.size() == 0) begin
                report("unexpected word, kind", 64'(o_result_kind), 64'd0);
            end else begin
                cache_result_t e;
                e = due_results.pop_front();
                if (o_result_kind  !== e.kind)
                    report("kind", 64'(o_result_kind), 64'(e.kind));
                if (o_mem_addr     !== e.addr)
                    report("addr", 64'(o_mem_addr), 64'(e.addr));
                if (o_result_data  !== e.data)  report("data", o_result_data, e.data);
                if (o_result_bytes !== e.bytes)
                    report("bytes", 64'(o_result_bytes), 64'(e.bytes));
                if (o_was_hit      !== e.hit)   report("hit", 64'(o_was_hit), 64'(e.hit));
                if (o_fault        !== e.fault)
                    report("fault", 64'(o_fault), 64'(e.fault));
            end
        end
    end

    function automatic access_row_t mk(logic [1:0] a, logic [31:0] ad, logic [3:0] n,
                                       logic [63:0] wv, logic [63:0] rw);
        return '{a, ad, n, wv, rw, 1'b0, '{default: '0}};
    endfunction

    function automatic access_row_t mk_fault(logic [1:0] a, logic [31:0] ad, logic [3:0] n);
        access_row_t w;
        w = mk(a, ad, n, '1, '1);
        w.known = 1;
        w.res = '{(a == ACT_READ) ? KIND_READ : KIND_WRITE, ad, 64'd0, n, 1'b0, 1'b1};
        return w;
    endfunction

    function automatic access_row_t mk_fetch(logic [31:0] ad, logic [3:0] n);
        access_row_t w;
        w = mk(ACT_READ, ad, n, '0, '0);
        w.known = 1;
        w.res = '{KIND_FETCH, {ad[31:4], 4'h0}, 64'd0, 4'd8, 1'b0, 1'b0};
        return w;
    endfunction

    function automatic access_row_t random_word();
        access_row_t w;
        logic [31:0] a;
        int n, off, pick;
        pick = $urandom_range(0, 99);
        w = mk(2'($urandom_range(0, 3)), $urandom, 4'($urandom_range(0, 15)),
               {$urandom, $urandom}, {$urandom, $urandom});
        if (pick < 8) return w;                        // noise
        if (miss_open) begin
            if (pick < 92) w.act = ACT_REFILL;
            return w;
        end
        a = addr_pool[$urandom_range(0, 15)];
        n = $urandom_range(1, 8);
        off = $urandom_range(0, LINE_BYTES - n);
        if (pick < 14) off = $urandom_range(0, LINE_BYTES - 1);   // may cross
        w.act = (pick < 60) ? ACT_READ : ACT_WRITE;
        w.addr = {a[31:4], 4'(off)};
        w.bytes = 4'(n);
        return w;
    endfunction

    initial begin
        access_row_t rows[$];
        access_row_t w;
        int burst, gap;
        logic [31:0] base;
        mismatches = 0;
        effective = 0;
        miss_open = 0;
        beat_idx = 0;
        lfsr = 16'd1;
        victim = '0;
        foreach (valid_mirror[k]) valid_mirror[k] = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_action = ACT_NONE;
        i_access_addr = '0;
        i_access_bytes = '0;
        i_write_value = '0;
        i_refill_word = '0;
        // few tags on few sets so that ways fill and evict
        for (int k = 0; k < 16; k++)
            addr_pool[k] = {22'($urandom_range(0, 5)) ^ 22'h2a5a5a, 6'($urandom_range(0, 3)), 4'h0};
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hffff_fff0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        base = 32'h1234_5670;
        rows.push_back(mk_fetch(base, 4'd4));
        rows.push_back(mk(ACT_REFILL, 0, 0, 0, 64'h8877_6655_4433_2211));
        rows.push_back(mk(ACT_REFILL, 0, 0, 0, 64'hffee_ddcc_bbaa_0099));
        rows.push_back(mk(ACT_READ, base + 8, 4'd8, 0, 0));
        rows.push_back(mk(ACT_WRITE, base + 2, 4'd2, 64'hdead_beef_cafe_a55a, 0));
        rows.push_back(mk(ACT_READ, base, 4'd8, 0, 0));
        rows.push_back(mk(ACT_WRITE, 32'h0, 4'd8, '1, 0));       // write miss
        rows.push_back(mk_fetch(32'hffff_ffff, 4'd1));
        rows.push_back(mk(ACT_READ, base, 4'd1, 0, 0));          // ignored, miss open
        rows.push_back(mk(ACT_WRITE, base, 4'd1, '1, 0));        // ignored, miss open
        rows.push_back(mk(ACT_REFILL, 0, 0, 0, '1));
        rows.push_back(mk(ACT_REFILL, 0, 0, 0, 64'h0123_4567_89ab_cdef));
        rows.push_back(mk_fault(ACT_READ, 32'hffff_ffff, 4'd2));  // crosses line end
        rows.push_back(mk_fault(ACT_WRITE, 32'h0000_000c, 4'd8));
        rows.push_back(mk_fault(ACT_READ, base, 4'd0));           // bad length
        rows.push_back(mk_fault(ACT_WRITE, base, 4'd9));
        rows.push_back(mk_fault(ACT_READ, 32'h0, 4'd15));
        rows.push_back(mk(ACT_NONE, '1, '1, '1, '1));
        rows.push_back(mk(ACT_REFILL, 0, 0, 0, '1));             // no miss open
        rows.push_back(mk(ACT_WRITE, 32'hffff_ffff, 4'd1, '1, 0));
        rows.push_back(mk(ACT_READ, 32'hffff_fff8, 4'd8, 0, 0));
        rows.push_back(mk(ACT_WRITE, 32'hffff_fff0, 4'd8, 64'h0, 0));
        rows.push_back(mk(ACT_READ, 32'hffff_fff0, 4'd8, 0, 0));
        foreach (rows[k]) send_word(rows[k]);

        burst = 0;
        effective = 0;
        while (effective < 1200) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            if (effective == 600) begin
                // drain fully once
                start <= 1'b0;
                while (due_results.size() != 0) @(posedge i_clk);
                repeat (4) @(posedge i_clk);
                effective++;
            end
            w = random_word();
            send_word(w);
            burst--;
        end
        start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/core/sawtc_pkg.sv
rtl/core/sawtc_ram.sv
rtl/core/sawtc_ctrl.sv
rtl/core/sawtc_dp.sv
rtl/core/set_assoc_write_through_cache_unit.sv
bench/tb.sv
